// ----- src/assert_macros.svh -----
// Assertion helpers for the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/pq_pkg.sv -----
package pq_pkg;

  // Storage geometry
  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Field widths
  localparam int CMD_W    = 2;
  localparam int VALUE_W  = 32;
  localparam int PRIO_W   = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int CAP_W    = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [CMD_W-1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_PEEK = 2'd2,
    OP_CLR  = 2'd3
  } pq_op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } pq_status_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic signed [PRIO_W-1:0]  prio;
  } pq_entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SHIFT_INIT,
    S_SHIFT,
    S_REPLY
  } pq_state_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;        // capture the accepted item
    logic do_enq;       // append at the tail
    logic do_clr;       // drop all entries
    logic set_full;
    logic set_empty;
    logic scan_start;   // read entry 0
    logic scan_cmp;     // compare the entry read last cycle
    logic scan_next;    // read the next entry
    logic shift_start;  // read the entry after the winner
    logic shift_wr;     // move read entry down one place
    logic shift_next;   // read the following entry
    logic pop;          // count minus one
    logic emit;         // load the output register
  } pq_ctl_t;

  // Datapath to controller
  typedef struct packed {
    pq_op_t op;
    logic   empty;
    logic   full;
    logic   scan_more;
    logic   best_has_next;
    logic   shift_more;
    logic   out_free;
  } pq_sts_t;

endpackage

// ----- src/pq_req_if.sv -----
interface pq_req_if import pq_pkg::*; ;
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          command;
  logic signed [VALUE_W-1:0] item_value;
  logic signed [PRIO_W-1:0]  item_priority;

  modport source (output valid, command, item_value, item_priority, input ready);
  modport sink   (input valid, command, item_value, item_priority, output ready);
endinterface

// ----- src/pq_rsp_if.sv -----
interface pq_rsp_if import pq_pkg::*; ;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] result_value;
  logic [STATUS_W-1:0]       status;
  logic [COUNT_W-1:0]        entry_count;
  logic                      full_flag;
  logic                      empty_flag;

  modport source (output valid, result_value, status, entry_count, full_flag, empty_flag,
                  input ready);
  modport sink   (input valid, result_value, status, entry_count, full_flag, empty_flag,
                  output ready);
endinterface

// ----- src/pq_cfg_if.sv -----
interface pq_cfg_if import pq_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacity_limit;

  modport source (output valid, capacity_limit, input ready);
  modport sink   (input valid, capacity_limit, output ready);
endinterface

// ----- src/priority_queue_linear_scan.sv -----
// Enqueue and clear: the accepted item passes through the execute and reply states to the output register.
// Peek: scans the N stored entries, one entry read per cycle from the RAM port.
// Dequeue: the peek scan, then the entries after the winner, if any, shift down one place.
// Next item is taken the cycle after the result is loaded; the result waits in the reply
// state until the output register is free for the receiver.
// Synchronous active-high reset empties the queue and sets the capacity to 16.
`include "assert_macros.svh"

module priority_queue_linear_scan import pq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  pq_req_if.sink   req,
  pq_rsp_if.source rsp,
  pq_cfg_if.sink   cfg
);

  pq_ctl_t ctl;
  pq_sts_t sts;

  pq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  pq_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .req_command (req.command),
    .req_value   (req.item_value),
    .req_prio    (req.item_priority),
    .cfg         (cfg),
    .rsp         (rsp),
    .ctl         (ctl),
    .sts         (sts)
  );

  // One item at a time: busy right after an accept
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, req.valid && req.ready, !req.ready, "busy missed")
  // Result only loaded into a free output slot
  `ASSERT_IMPL(a_emit_slot_free, clk, rst, ctl.emit, sts.out_free, "result overwrote pending item")
  // A loaded result is offered in the next cycle
  `ASSERT_NEXT(a_emit_valid, clk, rst, ctl.emit, rsp.valid, "loaded result not offered")
  // Enqueue only below the capacity
  `ASSERT_IMPL(a_enq_room, clk, rst, ctl.do_enq, !sts.full, "enqueue into full queue")

endmodule

// ----- src/pq_ram.sv -----
module pq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/pq_ctrl.sv -----
module pq_ctrl import pq_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_ready,
  input  pq_sts_t sts,
  output pq_ctl_t ctl
);

  pq_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        case (sts.op)
          OP_DEQ, OP_PEEK: begin
            state_next = sts.empty ? S_REPLY : S_SCAN;
          end
          default: state_next = S_REPLY;
        endcase
      end
      S_SCAN: begin
        if (!sts.scan_more) begin
          state_next = (sts.op == OP_DEQ) ? S_SHIFT_INIT : S_REPLY;
        end
      end
      S_SHIFT_INIT: begin
        state_next = sts.best_has_next ? S_SHIFT : S_REPLY;
      end
      S_SHIFT: begin
        if (!sts.shift_more) state_next = S_REPLY;
      end
      S_REPLY: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctl       = '0;
    req_ready = 1'b0;
    case (state)
      S_IDLE: begin
        // no item is taken while reset is held
        req_ready = !rst;
        ctl.latch = req_valid && !rst;
      end
      S_EXEC: begin
        case (sts.op)
          OP_ENQ: begin
            ctl.set_full = sts.full;
            ctl.do_enq   = !sts.full;
          end
          OP_DEQ, OP_PEEK: begin
            ctl.set_empty  = sts.empty;
            ctl.scan_start = !sts.empty;
          end
          default: ctl.do_clr = 1'b1;
        endcase
      end
      S_SCAN: begin
        ctl.scan_cmp  = 1'b1;
        ctl.scan_next = sts.scan_more;
      end
      S_SHIFT_INIT: begin
        ctl.shift_start = sts.best_has_next;
        ctl.pop         = !sts.best_has_next;
      end
      S_SHIFT: begin
        ctl.shift_wr   = 1'b1;
        ctl.shift_next = sts.shift_more;
        ctl.pop        = !sts.shift_more;
      end
      S_REPLY: begin
        ctl.emit = sts.out_free;
      end
      default: ;
    endcase
  end

endmodule

// ----- src/pq_dp.sv -----
module pq_dp import pq_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [CMD_W-1:0]          req_command,
  input  logic signed [VALUE_W-1:0] req_value,
  input  logic signed [PRIO_W-1:0]  req_prio,
  pq_cfg_if.sink                    cfg,
  pq_rsp_if.source                  rsp,
  input  pq_ctl_t                   ctl,
  output pq_sts_t                   sts
);

  localparam int CAP_XW = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // Capacity clamped to 1..DEPTH
  function automatic logic [CNT_W-1:0] eff_capacity(input logic [CAP_W-1:0] cap);
    logic [CAP_XW-1:0] c;
    c = CAP_XW'(cap);
    if (c == '0) c = CAP_XW'(1);
    if (c > CAP_XW'(DEPTH)) c = CAP_XW'(DEPTH);
    return CNT_W'(c);
  endfunction

  logic [CAP_W-1:0]          cap_limit;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          idx;
  logic [IDX_W-1:0]          best_idx;
  pq_entry_t                 best;
  pq_op_t                    op_q;
  logic signed [VALUE_W-1:0] val_q;
  logic signed [PRIO_W-1:0]  pri_q;
  pq_status_t                status_q;

  logic                      out_valid;
  logic signed [VALUE_W-1:0] out_value;
  pq_status_t                out_status;
  logic [COUNT_W-1:0]        out_count;
  logic                      out_full;
  logic                      out_empty;

  logic [CNT_W-1:0]           cap_eff;
  logic [CNT_W-1:0]           scan_tag;
  logic [CNT_W-1:0]           idx_inc;
  logic [CNT_W-1:0]           best_inc;
  logic                       is_full;
  logic                       result_ok;
  logic                       ram_we;
  logic [IDX_W-1:0]           ram_waddr;
  logic [$bits(pq_entry_t)-1:0] ram_wdata;
  logic [IDX_W-1:0]           ram_raddr;
  logic [$bits(pq_entry_t)-1:0] ram_rdata;
  pq_entry_t                  rd_entry;
  pq_entry_t                  enq_entry;

  assign cap_eff   = eff_capacity(cap_limit);
  assign scan_tag  = idx - CNT_W'(1);
  assign idx_inc   = idx + CNT_W'(1);
  assign best_inc  = CNT_W'(best_idx) + CNT_W'(1);
  assign is_full   = count >= cap_eff;
  assign rd_entry  = pq_entry_t'(ram_rdata);
  assign enq_entry = '{value: val_q, prio: pri_q};
  assign result_ok = (status_q == ST_OK) && ((op_q == OP_DEQ) || (op_q == OP_PEEK));

  // Entry store
  assign ram_we    = ctl.do_enq | ctl.shift_wr;
  assign ram_waddr = ctl.shift_wr ? scan_tag[IDX_W-1:0] : count[IDX_W-1:0];
  assign ram_wdata = ctl.shift_wr ? ram_rdata : enq_entry;

  always_comb begin
    if (ctl.scan_start)       ram_raddr = '0;
    else if (ctl.shift_start) ram_raddr = best_inc[IDX_W-1:0];
    else if (ctl.shift_next)  ram_raddr = idx_inc[IDX_W-1:0];
    else                      ram_raddr = idx[IDX_W-1:0];
  end

  pq_ram #(
    .WIDTH ($bits(pq_entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Capacity register, ready whenever reset is released
  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_limit <= CAP_RESET;
    end else if (cfg.valid && cfg.ready) begin
      cap_limit <= cfg.capacity_limit;
    end
  end

  // Occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.do_clr) begin
      count <= '0;
    end else if (ctl.do_enq) begin
      count <= count + CNT_W'(1);
    end else if (ctl.pop) begin
      count <= count - CNT_W'(1);
    end
  end

  // Item capture and status
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      op_q     <= pq_op_t'(req_command);
      val_q    <= req_value;
      pri_q    <= req_prio;
      status_q <= ST_OK;
    end else if (ctl.set_full) begin
      status_q <= ST_FULL;
    end else if (ctl.set_empty) begin
      status_q <= ST_EMPTY;
    end
  end

  // Scan / shift pointer
  always_ff @(posedge clk) begin
    if (ctl.scan_start) begin
      idx <= CNT_W'(1);
    end else if (ctl.shift_start) begin
      idx <= best_inc;
    end else if (ctl.scan_next || ctl.shift_next) begin
      idx <= idx_inc;
    end
  end

  // Running maximum, earliest entry kept on a tie
  always_ff @(posedge clk) begin
    if (ctl.scan_cmp && ((idx == CNT_W'(1)) || (rd_entry.prio > best.prio))) begin
      best     <= rd_entry;
      best_idx <= scan_tag[IDX_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_value  <= result_ok ? best.value : '0;
      out_status <= status_q;
      out_count  <= COUNT_W'(count);
      out_full   <= is_full;
      out_empty  <= (count == '0);
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.result_value = out_value;
  assign rsp.status       = out_status;
  assign rsp.entry_count  = out_count;
  assign rsp.full_flag    = out_full;
  assign rsp.empty_flag   = out_empty;

  // Status to controller
  assign sts.op            = op_q;
  assign sts.empty         = (count == '0);
  assign sts.full          = is_full;
  assign sts.scan_more     = idx < count;
  assign sts.best_has_next = best_inc < count;
  assign sts.shift_more    = idx_inc < count;
  assign sts.out_free      = !out_valid || rsp.ready;

endmodule
